// ===== sv/euler_to_quaternion_top_defines.svh =====
// assertion macros for the euler to quaternion block
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH
// condition implies consequence on the next clock
`define E2Q_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
// condition implies consequence in the same clock
`define E2Q_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
`endif

// ===== sv/e2q_pkg.sv =====
// shared constants, tables and types for the euler to quaternion block
package e2q_pkg;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int CORDIC_STEPS      = 30;
   localparam int CW                = 33;
   localparam int ZW                = 35;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef logic signed [CW-1:0] cord_type;
   typedef logic signed [ZW-1:0] phase_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0:  t = 32'h20000000;
         5'd1:  t = 32'h12E4051E;
         5'd2:  t = 32'h09FB385B;
         5'd3:  t = 32'h051111D4;
         5'd4:  t = 32'h028B0D43;
         5'd5:  t = 32'h0145D7E1;
         5'd6:  t = 32'h00A2F61E;
         5'd7:  t = 32'h00517C55;
         5'd8:  t = 32'h0028BE53;
         5'd9:  t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98;
         5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6;
         5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2F9;
         5'd15: t = 32'h0000517C;
         5'd16: t = 32'h000028BE;
         5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A2F;
         5'd19: t = 32'h00000517;
         5'd20: t = 32'h0000028B;
         5'd21: t = 32'h00000145;
         5'd22: t = 32'h000000A2;
         5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000028;
         5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A;
         5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000002;
         5'd29: t = 32'h00000001;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic valid;
      logic stall;
   } pipe_ctl_type;
endpackage

// ===== sv/e2q_cordic.sv =====
// pipelined rotation cordic giving cosine and sine of half a binary angle
module e2q_cordic import e2q_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [ANGLE_BITS-1:0] angle,
   output cord_type              cos_out,
   output cord_type              sin_out
);
   cord_type  x_ff [CORDIC_STEPS+1];
   cord_type  y_ff [CORDIC_STEPS+1];
   phase_type z_ff [CORDIC_STEPS+1];
   logic      flip_ff [CORDIC_STEPS+1];
   logic [32:0] ph;

   always_comb begin
      ph = 33'(angle) << (32 - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         flip_ff[0] <= ph[31];
         if (ph[31]) begin
            z_ff[0] <= $signed({2'b00, ph}) - $signed(35'sh100000000);
         end else begin
            z_ff[0] <= $signed({2'b00, ph});
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      cord_type  dx, dy;
      phase_type t;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign t  = $signed({2'b00, atan_entry(5'(i)), 1'b0});
      always_ff @(posedge clock) begin
         if (advance) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - t;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + t;
            end
         end
      end
   end

   assign cos_out = flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
   assign sin_out = flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
endmodule

// ===== sv/e2q_product.sv =====
// two-stage product tree and rounding of the quaternion components
module e2q_product import e2q_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            advance,
   input  cord_type                        cr, sr, cp, sp, cy, sy,
   output logic signed [FRACTION_BITS+1:0] qx, qy, qz, qw
);
   localparam int SH = 60 - FRACTION_BITS;
   localparam int RW = 66 - SH;
   localparam int OW = FRACTION_BITS + 2;

   cord_type cr_ff, sr_ff, cy_ff, sy_ff;
   cord_type cpcy_ff, spsy_ff, crsp_ff, srcp_ff, crcp_ff, srsp_ff;
   logic signed [65:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic signed [65:0] pz1_ff, pz2_ff, pw1_ff, pw2_ff;
   logic signed [OW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   function automatic cord_type mq(input cord_type a, input cord_type b);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b) + 66'sd536870912;
      return cord_type'(p >>> 30);
   endfunction

   function automatic logic signed [OW-1:0] fin(input logic signed [65:0] s);
      logic signed [65:0] r;
      logic signed [RW-1:0] t;
      logic signed [RW-1:0] lim;
      r   = s + (66'sd1 <<< (SH - 1));
      t   = RW'(r >>> SH);
      lim = RW'(1) <<< FRACTION_BITS;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return OW'(t);
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         cr_ff <= cr; sr_ff <= sr; cy_ff <= cy; sy_ff <= sy;
         cpcy_ff <= mq(cp, cy); spsy_ff <= mq(sp, sy);
         crsp_ff <= mq(cr, sp); srcp_ff <= mq(sr, cp);
         crcp_ff <= mq(cr, cp); srsp_ff <= mq(sr, sp);
         px1_ff <= 66'(sr_ff) * 66'(cpcy_ff);
         px2_ff <= 66'(cr_ff) * 66'(spsy_ff);
         py1_ff <= 66'(crsp_ff) * 66'(cy_ff);
         py2_ff <= 66'(srcp_ff) * 66'(sy_ff);
         pz1_ff <= 66'(crcp_ff) * 66'(sy_ff);
         pz2_ff <= 66'(srsp_ff) * 66'(cy_ff);
         pw1_ff <= 66'(cr_ff) * 66'(cpcy_ff);
         pw2_ff <= 66'(sr_ff) * 66'(spsy_ff);
         qx_ff <= fin(px1_ff - px2_ff);
         qy_ff <= fin(py1_ff + py2_ff);
         qz_ff <= fin(pz1_ff - pz2_ff);
         qw_ff <= fin(pw1_ff + pw2_ff);
      end
   end

   assign qx = qx_ff;
   assign qy = qy_ff;
   assign qz = qz_ff;
   assign qw = qw_ff;
endmodule

// ===== sv/euler_to_quaternion_top.sv =====
// throughput: one item per cycle sustained while the output is not stalled
// pipeline: 31 cordic stages, a half-angle product stage, a full product stage,
// a rounding stage; the whole pipe advances whenever the output slot is free
// or the last stage is empty
// reset: synchronous, active high, clears all stage valid bits
module euler_to_quaternion_top import e2q_pkg::*; #(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // roll_angle, pitch_angle, yaw_angle from the lowest bit up
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // quat_x, quat_y, quat_z, quat_w from the lowest bit up
   output logic [((4*(FRACTION_BITS+2)+7)/8)*8-1:0] rsp_tdata
);
   `include "euler_to_quaternion_top_defines.svh"
   localparam int DEPTH = CORDIC_STEPS + 4;
   localparam int OW    = FRACTION_BITS + 2;
   localparam int OTW   = ((4*OW+7)/8)*8;

   logic [DEPTH-1:0] vld_ff, vld_in;
   pipe_ctl_type ctl;
   cord_type cr, sr, cp, sp, cy, sy;
   logic signed [OW-1:0] qx, qy, qz, qw;

   assign ctl.valid = vld_ff[DEPTH-1];
   assign ctl.stall = ctl.valid && !rsp_tready;
   assign req_tready = !ctl.stall;

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!ctl.stall) begin
         vld_ff <= vld_in;
      end
   end

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .advance(!ctl.stall),
      .angle(req_tdata[ANGLE_BITS-1:0]), .cos_out(cr), .sin_out(sr));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .advance(!ctl.stall),
      .angle(req_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .cos_out(cp), .sin_out(sp));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .advance(!ctl.stall),
      .angle(req_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .cos_out(cy), .sin_out(sy));

   e2q_product #(.FRACTION_BITS(FRACTION_BITS)) u_prod (
      .clock(clock), .advance(!ctl.stall),
      .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
      .qx(qx), .qy(qy), .qz(qz), .qw(qw));

   assign rsp_tvalid = ctl.valid;
   assign rsp_tdata  = OTW'({qw, qz, qy, qx});

   `E2Q_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped while stalled")
   `E2Q_ASSERT_SAME(a_ready, clock, reset, !rsp_tvalid, req_tready,
      "input blocked with empty output")
   `E2Q_ASSERT_NEXT(a_enter, clock, reset, req_tvalid && req_tready, vld_ff[0],
      "accepted item not tracked")
endmodule
